// File: rtl/gpc_pkg.sv
`default_nettype none

package gpc_pkg;

  localparam int GLYPH_ENTRIES = 256;
  localparam int GLYPH_AW      = $clog2(GLYPH_ENTRIES);
  localparam int TABLE_W       = 24;

  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 16;

  // box edges: 16-bit signed coordinate plus an unsigned extent of up to 15 bits
  localparam int EDGE_W        = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIXED_PITCH = 4'd0,
    REG_FIXED_WIDTH = 4'd1,
    REG_FIRST_CODE  = 4'd2,
    REG_LAST_CODE   = 4'd3,
    REG_SPACE_CODE  = 4'd4,
    REG_CHAR_PAD    = 4'd5,
    REG_SPACE_PAD   = 4'd6,
    REG_FONT_HEIGHT = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic        fixed_pitch;
    logic [7:0]  fixed_width;
    logic [7:0]  first_code;
    logic [7:0]  last_code;
    logic [7:0]  space_code;
    logic [7:0]  char_pad;
    logic [10:0] space_pad;
    logic [7:0]  font_height;
  } cfg_t;

  // classified character item, handed from front to back
  typedef struct packed {
    logic              new_string;
    logic [15:0]       start_x;
    logic              in_range;
    logic [7:0]        width;
    logic [15:0]       advance;
    logic [15:0]       srcx;
    logic [EDGE_W-1:0] top;
    logic [EDGE_W-1:0] bottom;
    logic [EDGE_W-1:0] clip_l;
    logic [EDGE_W-1:0] clip_t;
    logic [EDGE_W-1:0] clip_r;
    logic [EDGE_W-1:0] clip_b;
  } qent_t;

endpackage

`default_nettype wire

// File: rtl/gpc_ram.sv
`default_nettype none

module gpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/gpc_front.sv
`default_nettype none

module gpc_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire gpc_pkg::cfg_t cfg,
  input  wire logic          push,
  output logic               full,
  input  wire logic          action,
  input  wire logic [7:0]    char_code,
  input  wire logic [15:0]   entry_xpos,
  input  wire logic [7:0]    entry_width,
  input  wire logic          new_string,
  input  wire logic [15:0]   start_x,
  input  wire logic [15:0]   line_y,
  input  wire logic [15:0]   clip_left,
  input  wire logic [15:0]   clip_top,
  input  wire logic [14:0]   clip_width,
  input  wire logic [14:0]   clip_height,
  output logic               q_push,
  output gpc_pkg::qent_t     q_data,
  input  wire logic          q_full
);

  typedef struct packed {
    logic                       new_string;
    logic [15:0]                start_x;
    logic                       in_range;
    logic [15:0]                fixed_srcx;
    logic [15:0]                pad;
    logic [gpc_pkg::EDGE_W-1:0] top;
    logic [gpc_pkg::EDGE_W-1:0] bottom;
    logic [gpc_pkg::EDGE_W-1:0] clip_l;
    logic [gpc_pkg::EDGE_W-1:0] clip_t;
    logic [gpc_pkg::EDGE_W-1:0] clip_r;
    logic [gpc_pkg::EDGE_W-1:0] clip_b;
  } stage_t;

  logic                             accept;
  logic [gpc_pkg::GLYPH_AW+7:0]     code_ext;
  logic [gpc_pkg::GLYPH_AW-1:0]     idx;
  logic [7:0]                       code_diff;
  logic [15:0]                      space_add;
  stage_t                           cls;
  stage_t                           s1;
  logic                             s1_valid;
  logic                             s1_valid_next;
  logic [gpc_pkg::TABLE_W-1:0]      tbl_rdata;
  logic [7:0]                       glyph_w;

  assign full   = s1_valid && q_full;
  assign accept = push && !full;

  assign code_ext = {{gpc_pkg::GLYPH_AW{1'b0}}, char_code};
  assign idx      = code_ext[gpc_pkg::GLYPH_AW-1:0];

  gpc_ram #(
    .WIDTH(gpc_pkg::TABLE_W),
    .DEPTH(gpc_pkg::GLYPH_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (accept && !action),
    .waddr(idx),
    .wdata({entry_xpos, entry_width}),
    .re   (accept && action),
    .raddr(idx),
    .rdata(tbl_rdata)
  );

  // classify the incoming character while the table read is in flight
  assign code_diff = char_code - cfg.first_code;
  assign space_add = (char_code == cfg.space_code) ?
                     {{5{cfg.space_pad[10]}}, cfg.space_pad} : 16'd0;

  always_comb begin
    cls.new_string = new_string;
    cls.start_x    = start_x;
    cls.in_range   = (char_code >= cfg.first_code) && (char_code <= cfg.last_code);
    cls.fixed_srcx = {8'd0, cfg.fixed_width} * {8'd0, code_diff};
    cls.pad        = {{8{cfg.char_pad[7]}}, cfg.char_pad} + space_add;
    cls.top        = {{2{line_y[15]}}, line_y};
    cls.bottom     = {{2{line_y[15]}}, line_y} + {10'd0, cfg.font_height};
    cls.clip_l     = {{2{clip_left[15]}}, clip_left};
    cls.clip_t     = {{2{clip_top[15]}}, clip_top};
    cls.clip_r     = {{2{clip_left[15]}}, clip_left} + {3'd0, clip_width};
    cls.clip_b     = {{2{clip_top[15]}}, clip_top} + {3'd0, clip_height};
  end

  always_comb begin
    s1_valid_next = s1_valid;
    if (q_push) begin
      s1_valid_next = 1'b0;
    end
    if (accept && action) begin
      s1_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && action) begin
      s1 <= cls;
    end
  end

  // pick glyph source and width, then hand the item to the back
  assign glyph_w = cfg.fixed_pitch ? cfg.fixed_width : tbl_rdata[7:0];
  assign q_push  = s1_valid && !q_full;

  always_comb begin
    q_data.new_string = s1.new_string;
    q_data.start_x    = s1.start_x;
    q_data.in_range   = s1.in_range;
    q_data.width      = glyph_w;
    q_data.advance    = {8'd0, glyph_w} + s1.pad;
    q_data.srcx       = cfg.fixed_pitch ? s1.fixed_srcx : tbl_rdata[23:8];
    q_data.top        = s1.top;
    q_data.bottom     = s1.bottom;
    q_data.clip_l     = s1.clip_l;
    q_data.clip_t     = s1.clip_t;
    q_data.clip_r     = s1.clip_r;
    q_data.clip_b     = s1.clip_b;
  end

endmodule

`default_nettype wire

// File: rtl/gpc_queue.sv
`default_nettype none

module gpc_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire gpc_pkg::qent_t push_data,
  output logic                full,
  input  wire logic           pop,
  output gpc_pkg::qent_t      head,
  output logic                empty
);

  gpc_pkg::qent_t                  mem [gpc_pkg::QUEUE_DEPTH];
  logic [gpc_pkg::QUEUE_AW-1:0]    wr_ptr;
  logic [gpc_pkg::QUEUE_AW-1:0]    rd_ptr;
  logic [gpc_pkg::QUEUE_AW:0]      count;
  logic [gpc_pkg::QUEUE_AW:0]      count_next;
  logic                            do_push;
  logic                            do_pop;

  assign full    = (count == (gpc_pkg::QUEUE_AW+1)'(gpc_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (do_push && !do_pop) begin
      count_next = count + 1'b1;
    end else if (do_pop && !do_push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/gpc_back.sv
`default_nettype none

module gpc_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_empty,
  input  wire gpc_pkg::qent_t q_data,
  output logic                q_pop,
  output logic                empty,
  input  wire logic           pop,
  output logic [15:0]         src_x,
  output logic [7:0]          src_y,
  output logic [15:0]         dst_x,
  output logic [15:0]         dst_y,
  output logic [7:0]          blit_width,
  output logic [7:0]          blit_height
);

  localparam int EW = gpc_pkg::EDGE_W;

  typedef struct packed {
    logic          in_range;
    logic [15:0]   srcx;
    logic [EW-1:0] left;
    logic [EW-1:0] right;
    logic [EW-1:0] top;
    logic [EW-1:0] bottom;
    logic [EW-1:0] clip_l;
    logic [EW-1:0] clip_t;
    logic [EW-1:0] clip_r;
    logic [EW-1:0] clip_b;
  } box_t;

  logic [15:0]   pen;
  logic [15:0]   pen_base;
  logic [15:0]   pen_next;
  box_t          box;
  box_t          a;
  logic          a_valid;
  logic          a_load;
  logic          a_done;
  logic          out_valid;
  logic          out_free;
  logic          out_load;
  logic [EW-1:0] il;
  logic [EW-1:0] ir;
  logic [EW-1:0] it;
  logic [EW-1:0] ib;
  logic [EW-1:0] x_off;
  logic [EW-1:0] w_vis;
  logic [EW-1:0] y_off;
  logic [EW-1:0] h_vis;
  logic          hit;

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;

  // intersect glyph box with the clip rectangle
  assign il  = ($signed(a.left) > $signed(a.clip_l)) ? a.left : a.clip_l;
  assign ir  = ($signed(a.right) < $signed(a.clip_r)) ? a.right : a.clip_r;
  assign it  = ($signed(a.top) > $signed(a.clip_t)) ? a.top : a.clip_t;
  assign ib  = ($signed(a.bottom) < $signed(a.clip_b)) ? a.bottom : a.clip_b;
  assign hit = a.in_range && ($signed(ir) > $signed(il)) && ($signed(ib) > $signed(it));

  assign x_off = il - a.left;
  assign w_vis = ir - il;
  assign y_off = it - a.top;
  assign h_vis = ib - it;

  assign out_load = a_valid && hit && out_free;
  assign a_done   = a_valid && (!hit || out_free);
  assign a_load   = !a_valid || a_done;
  assign q_pop    = !q_empty && a_load;

  // pen update: one add per in-range character
  assign pen_base = q_data.new_string ? q_data.start_x : pen;

  always_comb begin
    pen_next = pen;
    if (q_pop) begin
      pen_next = q_data.in_range ? pen_base + q_data.advance : pen_base;
    end
  end

  always_comb begin
    box.in_range = q_data.in_range;
    box.srcx     = q_data.srcx;
    box.left     = {{2{pen_base[15]}}, pen_base};
    box.right    = {{2{pen_base[15]}}, pen_base} + {10'd0, q_data.width};
    box.top      = q_data.top;
    box.bottom   = q_data.bottom;
    box.clip_l   = q_data.clip_l;
    box.clip_t   = q_data.clip_t;
    box.clip_r   = q_data.clip_r;
    box.clip_b   = q_data.clip_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen       <= '0;
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pen <= pen_next;
      if (a_load) begin
        a_valid <= q_pop;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a <= box;
    end
    if (out_load) begin
      src_x       <= a.srcx + x_off[15:0];
      src_y       <= y_off[7:0];
      dst_x       <= il[15:0];
      dst_y       <= it[15:0];
      blit_width  <= w_vis[7:0];
      blit_height <= h_vis[7:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/glyph_placement_clip.sv
// Glyph placement and clipping for a text blitter.
//
// Input channel: a queue write port (push/full). An item either loads one
// glyph table entry (action low: strip x position and width at char_code) or
// places one character (action high) at the pen, optionally reloading the pen
// from start_x first. Result channel: a queue read port (empty/pop); each
// result is one blit command for the visible part of a glyph. Characters that
// are outside first_code..last_code, or whose box misses the clip rectangle,
// produce no result. Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data;
// cfg_ready is always high; write registers only while the block is idle.
//
// Throughput: one item per cycle while full is low. A placed character
// passes the table read and front stage (loaded on the accepting edge), the
// queue, the pen-update box register and the clip result register in turn.
// A stalled receiver holds the result register; the box register, the
// four-entry queue and the front stage absorb items until full rises.
// Reset: synchronous; clears the pen, the queue and all valid flags, and
// loads register defaults. Glyph table contents are undefined until written.

`default_nettype none

module glyph_placement_clip (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [gpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gpc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic                           action,
  input  wire logic [7:0]                     char_code,
  input  wire logic [15:0]                    entry_xpos,
  input  wire logic [7:0]                     entry_width,
  input  wire logic                           new_string,
  input  wire logic [15:0]                    start_x,
  input  wire logic [15:0]                    line_y,
  input  wire logic [15:0]                    clip_left,
  input  wire logic [15:0]                    clip_top,
  input  wire logic [14:0]                    clip_width,
  input  wire logic [14:0]                    clip_height,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [15:0]                         src_x,
  output logic [7:0]                          src_y,
  output logic [15:0]                         dst_x,
  output logic [15:0]                         dst_y,
  output logic [7:0]                          blit_width,
  output logic [7:0]                          blit_height
);

  gpc_pkg::cfg_t  cfg;
  gpc_pkg::qent_t q_in;
  gpc_pkg::qent_t q_head;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;

  // register file: always ready, unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fixed_pitch <= 1'b0;
      cfg.fixed_width <= 8'd8;
      cfg.first_code  <= 8'd0;
      cfg.last_code   <= 8'd255;
      cfg.space_code  <= 8'd32;
      cfg.char_pad    <= 8'd0;
      cfg.space_pad   <= 11'd0;
      cfg.font_height <= 8'd16;
    end else if (cfg_valid && cfg_ready) begin
      unique case (gpc_pkg::cfg_reg_t'(cfg_index))
        gpc_pkg::REG_FIXED_PITCH: cfg.fixed_pitch <= cfg_data[0];
        gpc_pkg::REG_FIXED_WIDTH: cfg.fixed_width <= cfg_data[7:0];
        gpc_pkg::REG_FIRST_CODE:  cfg.first_code  <= cfg_data[7:0];
        gpc_pkg::REG_LAST_CODE:   cfg.last_code   <= cfg_data[7:0];
        gpc_pkg::REG_SPACE_CODE:  cfg.space_code  <= cfg_data[7:0];
        gpc_pkg::REG_CHAR_PAD:    cfg.char_pad    <= cfg_data[7:0];
        gpc_pkg::REG_SPACE_PAD:   cfg.space_pad   <= cfg_data[10:0];
        gpc_pkg::REG_FONT_HEIGHT: cfg.font_height <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // front: accept, write or read the glyph table, classify
  gpc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .full       (full),
    .action     (action),
    .char_code  (char_code),
    .entry_xpos (entry_xpos),
    .entry_width(entry_width),
    .new_string (new_string),
    .start_x    (start_x),
    .line_y     (line_y),
    .clip_left  (clip_left),
    .clip_top   (clip_top),
    .clip_width (clip_width),
    .clip_height(clip_height),
    .q_push     (q_push),
    .q_data     (q_in),
    .q_full     (q_full)
  );

  // decoupling queue between front and back
  gpc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // back: advance the pen, clip, hold the result
  gpc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_data     (q_head),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .src_x      (src_x),
    .src_y      (src_y),
    .dst_x      (dst_x),
    .dst_y      (dst_y),
    .blit_width (blit_width),
    .blit_height(blit_height)
  );

endmodule

`default_nettype wire
